@@ hdl/spa_pkg.sv @@
// Shared types and constants for the sync-driven pixel averager.
package spa_pkg;

    // Event codes on the func input.
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_PIXEL  = 2'd1;
    localparam logic [1:0] FUNC_LINE   = 2'd2;
    localparam logic [1:0] FUNC_FRAME  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 13;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_WIDTH = 2'd1;

    // Fixed field widths.
    localparam int unsigned FUNC_BITS     = 2;
    localparam int unsigned SAMPLE_IN_BITS = 12;
    localparam int unsigned FAP_BITS      = 12;
    localparam int unsigned AW_BITS       = 13;
    localparam int unsigned COLUMN_BITS   = 12;
    localparam int unsigned POS_BITS      = 16;
    localparam int unsigned MEAN_BITS     = 12;

    // Reset values and limits.
    localparam logic [FAP_BITS-1:0]  FAP_RESET         = 12'd44;
    localparam logic [AW_BITS-1:0]   AW_RESET          = 13'd512;
    localparam logic [POS_BITS-1:0]  FRAME_PIXEL_START = 16'd2;
    localparam logic [POS_BITS-1:0]  POS_MAX           = 16'hFFFF;
    localparam logic [MEAN_BITS-1:0] MEAN_MAX          = 12'hFFF;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic start_div;
        logic div_step;
        logic mean_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_window;
        logic count_zero;
    } dp_status_t;

endpackage

@@ hdl/spa_datapath.sv @@
// Datapath: configuration, sample accumulator, position counters, divider and result registers.
module spa_datapath #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [spa_pkg::CFG_IDX_BITS-1:0]      wr_index,
    input  logic [spa_pkg::CFG_DATA_BITS-1:0]     wr_data,
    input  logic [spa_pkg::FUNC_BITS-1:0]         func,
    input  logic [spa_pkg::SAMPLE_IN_BITS-1:0]    sample_value,
    input  spa_pkg::ctrl_cmd_t                    cmd,
    output spa_pkg::dp_status_t                   status,
    output logic                                  is_frame_marker,
    output logic [spa_pkg::COLUMN_BITS-1:0]       column,
    output logic [spa_pkg::POS_BITS-1:0]          line_number,
    output logic [spa_pkg::MEAN_BITS-1:0]         mean_value,
    output logic                                  no_samples
);

    localparam int unsigned SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int unsigned SW        = (SAMPLE_BITS < spa_pkg::SAMPLE_IN_BITS) ?
                                        SAMPLE_BITS : spa_pkg::SAMPLE_IN_BITS;
    localparam int unsigned EXT_BITS  = (SAMPLE_BITS > spa_pkg::MEAN_BITS) ?
                                        SAMPLE_BITS : spa_pkg::MEAN_BITS;
    localparam int unsigned WEND_BITS = spa_pkg::AW_BITS + 1;
    localparam int unsigned CMP_BITS  = spa_pkg::POS_BITS + 1;

    logic [spa_pkg::FAP_BITS-1:0]  fap_reg, fap_next;
    logic [spa_pkg::AW_BITS-1:0]   aw_reg, aw_next;
    logic [SUM_BITS-1:0]           sum_reg, sum_next;
    logic [COUNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [spa_pkg::POS_BITS-1:0]  pix_reg, pix_next;
    logic [spa_pkg::POS_BITS-1:0]  line_reg, line_next;

    logic [COUNT_BITS-1:0]         rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]        dq_reg, dq_next;
    logic [COUNT_BITS-1:0]         dvs_reg, dvs_next;

    logic                          marker_reg, marker_next;
    logic [spa_pkg::COLUMN_BITS-1:0] column_reg, column_next;
    logic [spa_pkg::POS_BITS-1:0]  line_out_reg, line_out_next;
    logic [spa_pkg::MEAN_BITS-1:0] mean_reg, mean_next;
    logic                          nos_reg, nos_next;

    logic [WEND_BITS-1:0]          window_end;
    logic [spa_pkg::POS_BITS-1:0]  pix_offset;
    logic [SAMPLE_BITS-1:0]        sample_ext;
    logic                          count_full;
    logic [COUNT_BITS:0]           trial;
    logic [COUNT_BITS:0]           trial_diff;
    logic                          trial_ge;
    logic [EXT_BITS-1:0]           quot_ext;
    logic [spa_pkg::MEAN_BITS-1:0] quot_sat;

    // Active window test against the current pixel counter.
    assign window_end = WEND_BITS'(fap_reg) + WEND_BITS'(aw_reg);
    assign status.in_window = (pix_reg >= spa_pkg::POS_BITS'(fap_reg)) &&
                              (CMP_BITS'(pix_reg) < CMP_BITS'(window_end));
    assign status.count_zero = (cnt_reg == '0);
    assign pix_offset = pix_reg - spa_pkg::POS_BITS'(fap_reg);

    // Sample conditioning and accumulator limit.
    assign sample_ext = SAMPLE_BITS'(sample_value[SW-1:0]);
    assign count_full = (cnt_reg == {COUNT_BITS{1'b1}});

    // One restoring division step per cycle.
    assign trial      = {rem_reg, dq_reg[SAMPLE_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, dvs_reg});
    assign trial_diff = trial - {1'b0, dvs_reg};

    // Quotient clamped to the mean field.
    assign quot_ext = EXT_BITS'(dq_reg);
    assign quot_sat = (quot_ext > EXT_BITS'(spa_pkg::MEAN_MAX)) ?
                      spa_pkg::MEAN_MAX : quot_ext[spa_pkg::MEAN_BITS-1:0];

    // Next-state logic for configuration, accumulator and counters.
    always_comb
    begin
        fap_next  = fap_reg;
        aw_next   = aw_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        pix_next  = pix_reg;
        line_next = line_reg;

        if (wr_en)
        begin
            case (wr_index)
                spa_pkg::CFG_FIRST_ACTIVE: fap_next = wr_data[spa_pkg::FAP_BITS-1:0];
                spa_pkg::CFG_ACTIVE_WIDTH: aw_next  = wr_data;
                default: ;
            endcase
        end

        if (cmd.take_item)
        begin
            case (func)
                spa_pkg::FUNC_SAMPLE:
                begin
                    if (!count_full)
                    begin
                        sum_next = sum_reg + SUM_BITS'(sample_ext);
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                spa_pkg::FUNC_PIXEL:
                begin
                    sum_next = '0;
                    cnt_next = '0;
                    if (pix_reg != spa_pkg::POS_MAX)
                    begin
                        pix_next = pix_reg + 1'b1;
                    end
                end
                spa_pkg::FUNC_LINE:
                begin
                    pix_next = '0;
                    if (line_reg != spa_pkg::POS_MAX)
                    begin
                        line_next = line_reg + 1'b1;
                    end
                end
                default:
                begin
                    line_next = '0;
                    pix_next  = spa_pkg::FRAME_PIXEL_START;
                end
            endcase
        end
    end

    // Next-value logic for the divider and result registers.
    always_comb
    begin
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        dvs_next      = dvs_reg;
        marker_next   = marker_reg;
        column_next   = column_reg;
        line_out_next = line_out_reg;
        mean_next     = mean_reg;
        nos_next      = nos_reg;

        if (cmd.start_div)
        begin
            rem_next = sum_reg[SUM_BITS-1:SAMPLE_BITS];
            dq_next  = sum_reg[SAMPLE_BITS-1:0];
            dvs_next = cnt_reg;
        end
        else if (cmd.div_step)
        begin
            rem_next = trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            dq_next  = {dq_reg[SAMPLE_BITS-2:0], trial_ge};
        end

        // Record fields are staged when the event is taken.
        if (cmd.take_item && (func == spa_pkg::FUNC_FRAME))
        begin
            marker_next   = 1'b1;
            column_next   = '0;
            line_out_next = '0;
            mean_next     = '0;
            nos_next      = 1'b0;
        end
        else if (cmd.take_item && (func == spa_pkg::FUNC_PIXEL))
        begin
            marker_next   = 1'b0;
            column_next   = pix_offset[spa_pkg::COLUMN_BITS-1:0];
            line_out_next = line_reg;
            mean_next     = '0;
            nos_next      = status.count_zero;
        end
        else if (cmd.mean_load)
        begin
            mean_next = quot_sat;
        end
    end

    // Control-relevant state: configuration, accumulator and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fap_reg  <= spa_pkg::FAP_RESET;
            aw_reg   <= spa_pkg::AW_RESET;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            pix_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            fap_reg  <= fap_next;
            aw_reg   <= aw_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            pix_reg  <= pix_next;
            line_reg <= line_next;
        end
    end

    // Divider and result payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        dvs_reg      <= dvs_next;
        marker_reg   <= marker_next;
        column_reg   <= column_next;
        line_out_reg <= line_out_next;
        mean_reg     <= mean_next;
        nos_reg      <= nos_next;
    end

    assign is_frame_marker = marker_reg;
    assign column          = column_reg;
    assign line_number     = line_out_reg;
    assign mean_value      = mean_reg;
    assign no_samples      = nos_reg;

endmodule

@@ hdl/spa_controller.sv @@
// Controller: event sequencing, divider step count and result valid.
module spa_controller #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [spa_pkg::FUNC_BITS-1:0] func,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  spa_pkg::dp_status_t           status,
    output spa_pkg::ctrl_cmd_t            cmd
);

    localparam int unsigned STEP_BITS = $clog2(SAMPLE_BITS);

    spa_pkg::state_t        state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   makes_record;
    logic                   take;

    // Pixel edges and frame syncs may produce a record, so they wait for a free output.
    assign makes_record = (func == spa_pkg::FUNC_PIXEL) || (func == spa_pkg::FUNC_FRAME);
    assign in_stall     = (state_reg != spa_pkg::ST_IDLE) || (out_valid_reg && makes_record);
    assign take         = in_valid && !in_stall;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.take_item  = take;
        cmd.start_div  = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.mean_load  = 1'b0;

        case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                if (take && (func == spa_pkg::FUNC_FRAME))
                begin
                    out_valid_next = 1'b1;
                end
                else if (take && (func == spa_pkg::FUNC_PIXEL) && status.in_window)
                begin
                    if (status.count_zero)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.start_div = 1'b1;
                        step_next     = STEP_BITS'(SAMPLE_BITS - 1);
                        state_next    = spa_pkg::ST_DIVIDE;
                    end
                end
            end
            spa_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = spa_pkg::ST_FINISH;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            spa_pkg::ST_FINISH:
            begin
                cmd.mean_load  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = spa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spa_pkg::ST_IDLE;
            end
        endcase
    end

    // State, step counter and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spa_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // No new event enters while a division is in progress.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != spa_pkg::ST_IDLE) |-> in_stall)
        else $error("event accepted while divider busy");

    // The output slot is empty for the whole division.
    a_div_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spa_pkg::ST_DIVIDE) |-> !out_valid_reg)
        else $error("result pending during division");

    // The finishing cycle always presents a record next.
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spa_pkg::ST_FINISH) |=> out_valid_reg)
        else $error("averaged record not presented");

    // A record-producing event is never taken over a pending record.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (take && makes_record) |-> !out_valid_reg)
        else $error("pending record overwritten");
`endif

endmodule

@@ hdl/sync_driven_pixel_averager.sv @@
// Top level of the sync-driven pixel averager: controller and datapath.
// Samples and line syncs make no record, nor does a pixel edge outside the active window.
// For a frame sync or an in-window pixel edge with no samples, the record is valid on
// the next cycle. An in-window pixel edge with samples runs the one-bit-per-cycle
// restoring divider through ST_DIVIDE and ST_FINISH; no event is taken until ST_IDLE.
// Pixel edges and frame syncs wait while a record is still pending at the output.
// rst_n clears counters, accumulator and control at once and loads the register defaults.
module sync_driven_pixel_averager #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [spa_pkg::CFG_IDX_BITS-1:0]    wr_index,
    input  logic [spa_pkg::CFG_DATA_BITS-1:0]   wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spa_pkg::FUNC_BITS-1:0]       func,
    input  logic [spa_pkg::SAMPLE_IN_BITS-1:0]  sample_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_frame_marker,
    output logic [spa_pkg::COLUMN_BITS-1:0]     column,
    output logic [spa_pkg::POS_BITS-1:0]        line_number,
    output logic [spa_pkg::MEAN_BITS-1:0]       mean_value,
    output logic                                no_samples
);

    spa_pkg::ctrl_cmd_t  cmd;
    spa_pkg::dp_status_t status;

    // Sequencing of events and the divider.
    spa_controller #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Accumulation, counters, division and record fields.
    spa_datapath #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .func            (func),
        .sample_value    (sample_value),
        .cmd             (cmd),
        .status          (status),
        .is_frame_marker (is_frame_marker),
        .column          (column),
        .line_number     (line_number),
        .mean_value      (mean_value),
        .no_samples      (no_samples)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the sync-driven pixel averager: directed rows and random scans.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SMP_BITS      = 12;
    localparam int unsigned CNT_BITS      = 16;
    localparam int unsigned SETTLE_CYCLES = SMP_BITS + 8;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned PHASE_ITEMS   = 125;
    localparam int unsigned PRINT_CAP     = 50;
    localparam logic [spa_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [spa_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [CNT_BITS-1:0]              COUNT_FULL   = '1;

    // One output record as it leaves the block.
    typedef struct packed {
        logic                            marker;
        logic [spa_pkg::COLUMN_BITS-1:0] col;
        logic [spa_pkg::POS_BITS-1:0]    line;
        logic [spa_pkg::MEAN_BITS-1:0]   mean;
        logic                            empty;
    } pixel_rec_t;

    // How a directed row gets its expectation.
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_QUIET
    } row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [spa_pkg::FUNC_BITS-1:0]      ev;
        logic [spa_pkg::SAMPLE_IN_BITS-1:0] smp;
        logic [7:0]                         reps;
        pixel_rec_t                         rec;
    } stim_row_t;

    localparam pixel_rec_t NO_REC    = '0;
    localparam pixel_rec_t FRAME_REC = '{1'b1, 12'd0, 16'd0, 12'd0, 1'b0};

    // Block ports.
    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               wr_en        = 1'b0;
    logic [spa_pkg::CFG_IDX_BITS-1:0]   wr_index     = '0;
    logic [spa_pkg::CFG_DATA_BITS-1:0]  wr_data      = '0;
    logic                               in_valid     = 1'b0;
    logic                               in_stall;
    logic [spa_pkg::FUNC_BITS-1:0]      func         = '0;
    logic [spa_pkg::SAMPLE_IN_BITS-1:0] sample_value = '0;
    logic                               out_valid;
    logic                               out_stall    = 1'b0;
    logic                               is_frame_marker;
    logic [spa_pkg::COLUMN_BITS-1:0]    column;
    logic [spa_pkg::POS_BITS-1:0]       line_number;
    logic [spa_pkg::MEAN_BITS-1:0]      mean_value;
    logic                               no_samples;

    // Scan state and registers as the testbench tracks them.
    logic [SMP_BITS+CNT_BITS-1:0]  acc_sum   = '0;
    logic [CNT_BITS-1:0]           acc_count = '0;
    logic [spa_pkg::POS_BITS-1:0]  pix_pos   = '0;
    logic [spa_pkg::POS_BITS-1:0]  line_pos  = '0;
    logic [spa_pkg::FAP_BITS-1:0]  cfg_first = spa_pkg::FAP_RESET;
    logic [spa_pkg::AW_BITS-1:0]   cfg_width = spa_pkg::AW_RESET;

    pixel_rec_t  pending_records [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned in_idle_pct    = 0;
    int unsigned out_idle_pct   = 0;
    int unsigned stall_left     = 0;

    // Directed rows, run at the register reset values (window starts at pixel 44).
    stim_row_t directed_rows [23] = '{
        '{ROW_TYPED,     spa_pkg::FUNC_FRAME,  12'h000, 8'd1,  FRAME_REC},
        '{ROW_QUIET,     spa_pkg::FUNC_PIXEL,  12'h000, 8'd42, NO_REC},
        '{ROW_TYPED, spa_pkg::FUNC_PIXEL, 12'hFFF, 8'd1, '{1'b0, 12'd0, 16'd0, 12'd0, 1'b1}},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'h000, 8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'hFFF, 8'd1,  NO_REC},
        '{ROW_TYPED, spa_pkg::FUNC_PIXEL, 12'h000, 8'd1, '{1'b0, 12'd1, 16'd0, 12'd2047, 1'b0}},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'hFFF, 8'd1,  NO_REC},
        '{ROW_TYPED, spa_pkg::FUNC_PIXEL, 12'h000, 8'd1, '{1'b0, 12'd2, 16'd0, 12'd4095, 1'b0}},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'hAAA, 8'd1,  NO_REC},
        '{ROW_QUIET,     spa_pkg::FUNC_LINE,   12'h555, 8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'h555, 8'd1,  NO_REC},
        '{ROW_QUIET,     spa_pkg::FUNC_PIXEL,  12'hAAA, 8'd44, NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'd7,   8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'd8,   8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'd9,   8'd1,  NO_REC},
        '{ROW_TYPED, spa_pkg::FUNC_PIXEL, 12'h000, 8'd1, '{1'b0, 12'd0, 16'd1, 12'd8, 1'b0}},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'd10,  8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_SAMPLE, 12'd21,  8'd1,  NO_REC},
        '{ROW_TYPED,     spa_pkg::FUNC_FRAME,  12'hFFF, 8'd1,  FRAME_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_LINE,   12'h000, 8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_LINE,   12'hFFF, 8'd1,  NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_PIXEL,  12'h000, 8'd44, NO_REC},
        '{ROW_PREDICTED, spa_pkg::FUNC_PIXEL,  12'h000, 8'd1,  NO_REC}
    };

    sync_driven_pixel_averager #(
        .SAMPLE_BITS(SMP_BITS),
        .COUNT_BITS (CNT_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_frame_marker(is_frame_marker),
        .column         (column),
        .line_number    (line_number),
        .mean_value     (mean_value),
        .no_samples     (no_samples)
    );

    always #1 clk = ~clk;

    // Advance the scan state by one event and return the record it produces, if any.
    function automatic bit advance_scan(input logic [spa_pkg::FUNC_BITS-1:0] ev,
                                        input logic [spa_pkg::SAMPLE_IN_BITS-1:0] smp,
                                        output pixel_rec_t rec);
        int unsigned                  win_end;
        logic [SMP_BITS+CNT_BITS-1:0] quotient;
        bit                           hit;
        rec = '0;
        hit = 1'b0;
        case (ev)
            spa_pkg::FUNC_SAMPLE:
            begin
                // A full sample count freezes both the sum and the count.
                if (acc_count != COUNT_FULL)
                begin
                    acc_sum   = acc_sum + smp;
                    acc_count = acc_count + 1'b1;
                end
            end
            spa_pkg::FUNC_PIXEL:
            begin
                win_end = cfg_first + cfg_width;
                if (pix_pos >= cfg_first && pix_pos < win_end)
                begin
                    hit      = 1'b1;
                    rec.col  = spa_pkg::COLUMN_BITS'(pix_pos - cfg_first);
                    rec.line = line_pos;
                    if (acc_count == '0)
                        rec.empty = 1'b1;
                    else
                    begin
                        quotient = acc_sum / acc_count;
                        rec.mean = (quotient > spa_pkg::MEAN_MAX) ?
                                   spa_pkg::MEAN_MAX : quotient[spa_pkg::MEAN_BITS-1:0];
                    end
                end
                // The accumulator clears on every pixel edge, in the window or not.
                acc_sum   = '0;
                acc_count = '0;
                if (pix_pos != spa_pkg::POS_MAX)
                    pix_pos = pix_pos + 1'b1;
            end
            spa_pkg::FUNC_LINE:
            begin
                pix_pos = '0;
                if (line_pos != spa_pkg::POS_MAX)
                    line_pos = line_pos + 1'b1;
            end
            default:
            begin
                // Frame sync keeps the accumulator but restarts the line and pixel counts.
                hit        = 1'b1;
                rec.marker = 1'b1;
                line_pos   = '0;
                pix_pos    = spa_pkg::FRAME_PIXEL_START;
            end
        endcase
        return hit;
    endfunction

    function automatic int unsigned pause_length();
        return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic logic [spa_pkg::SAMPLE_IN_BITS-1:0] rand_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        return spa_pkg::SAMPLE_IN_BITS'($urandom_range(0, 4095));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Present one request, hold it until accepted, then record what it should produce.
    task automatic send_event(input logic [spa_pkg::FUNC_BITS-1:0] ev,
                              input logic [spa_pkg::SAMPLE_IN_BITS-1:0] smp, output bit made);
        pixel_rec_t rec;
        in_valid     <= 1'b1;
        func         <= ev;
        sample_value <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        made = advance_scan(ev, smp, rec);
        if (made)
            pending_records.push_back(rec);
    endtask

    task automatic maybe_pause();
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat (pause_length())
                @(posedge clk);
        end
    endtask

    task automatic issue(input logic [spa_pkg::FUNC_BITS-1:0] ev,
                         input logic [spa_pkg::SAMPLE_IN_BITS-1:0] smp);
        bit made;
        send_event(ev, smp, made);
        maybe_pause();
    endtask

    // Wait until every record has come out and the block has had time to finish.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [spa_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [spa_pkg::CFG_DATA_BITS-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            spa_pkg::CFG_FIRST_ACTIVE: cfg_first = data[spa_pkg::FAP_BITS-1:0];
            spa_pkg::CFG_ACTIVE_WIDTH: cfg_width = data[spa_pkg::AW_BITS-1:0];
            default: ;
        endcase
    endtask

    // Reprogram the window once the block is idle; a write to an unused index rides along.
    task automatic configure(input logic [spa_pkg::CFG_DATA_BITS-1:0] first_data,
                             input logic [spa_pkg::CFG_DATA_BITS-1:0] width_data);
        wait_until_idle();
        write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                       spa_pkg::CFG_DATA_BITS'($urandom_range(0, 8191)));
        write_register(spa_pkg::CFG_FIRST_ACTIVE, first_data);
        write_register(spa_pkg::CFG_ACTIVE_WIDTH, width_data);
        wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        stim_row_t row;
        bit        made;
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
            begin
                send_event(row.ev, row.smp, made);
                // Rows with a typed answer replace whatever the predictor queued.
                if (row.kind != ROW_PREDICTED)
                begin
                    if (made)
                        void'(pending_records.pop_back());
                    if (row.kind == ROW_TYPED)
                        pending_records.push_back(row.rec);
                end
                maybe_pause();
            end
        end
    endtask

    // One scan line: a sync, then pixels made of a few samples and an edge.
    task automatic send_scan_line();
        int unsigned span;
        int unsigned n_smp;
        int unsigned roll;
        // Stray samples ahead of a sync check that syncs keep the accumulator.
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 3))
                issue(spa_pkg::FUNC_SAMPLE, rand_sample());
        issue(($urandom_range(99) < 12) ? spa_pkg::FUNC_FRAME : spa_pkg::FUNC_LINE,
              rand_sample());
        span = cfg_first + cfg_width + 2;
        if (span > 14)
            span = 14;
        repeat ($urandom_range(1, span))
        begin
            roll = $urandom_range(99);
            if (roll < 15)
                n_smp = 0;
            else if (roll < 20)
                n_smp = $urandom_range(12, 24);
            else
                n_smp = $urandom_range(1, 5);
            repeat (n_smp)
                issue(spa_pkg::FUNC_SAMPLE, rand_sample());
            issue(spa_pkg::FUNC_PIXEL, rand_sample());
        end
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 4))
                    issue(spa_pkg::FUNC_BITS'($urandom_range(spa_pkg::FUNC_FRAME)),
                          rand_sample());
            else
                send_scan_line();
        end
    endtask

    // Output side: check each accepted record and drive random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_records.size() == 0)
                    report_mismatch("record with none expected");
                else
                begin
                    compare_field("is_frame_marker", 16'(is_frame_marker),
                                  16'(pending_records[0].marker));
                    compare_field("column", 16'(column), 16'(pending_records[0].col));
                    compare_field("line_number", line_number, pending_records[0].line);
                    compare_field("mean_value", 16'(mean_value), 16'(pending_records[0].mean));
                    compare_field("no_samples", 16'(no_samples),
                                  16'(pending_records[0].empty));
                    void'(pending_records.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left = stall_left - 1;
            end
            else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct)
            begin
                out_stall  <= 1'b1;
                stall_left = pause_length() - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** sync_driven_pixel_averager: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at the register reset values.
        in_idle_pct  = 20;
        out_idle_pct = 20;
        run_directed();

        // Random scans over a range of windows, extremes included.
        in_idle_pct  = 30;
        out_idle_pct = 30;
        configure(13'd2, 13'd3);
        run_random_phase(PHASE_ITEMS);
        // Bit 12 of the first-pixel write is dropped, leaving zero.
        configure(13'h1000, 13'd1);
        run_random_phase(PHASE_ITEMS);
        in_idle_pct  = 30;
        out_idle_pct = 40;
        configure(13'd0, 13'd0);
        run_random_phase(PHASE_ITEMS);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        configure(13'd1, 13'd4096);
        run_random_phase(PHASE_ITEMS);
        in_idle_pct  = 20;
        out_idle_pct = 20;
        configure(13'd3, 13'h1FFF);
        run_random_phase(PHASE_ITEMS);
        in_idle_pct  = 50;
        out_idle_pct = 50;
        configure(spa_pkg::CFG_DATA_BITS'($urandom_range(0, 6)),
                  spa_pkg::CFG_DATA_BITS'($urandom_range(1, 10)));
        run_random_phase(PHASE_ITEMS);

        // A one-pixel window at 0, then a frame sync that moves the pixel count to 2.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        configure(13'd0, 13'd1);
        issue(spa_pkg::FUNC_LINE, rand_sample());
        issue(spa_pkg::FUNC_SAMPLE, 12'hFFF);
        issue(spa_pkg::FUNC_SAMPLE, 12'hFFE);
        issue(spa_pkg::FUNC_PIXEL, rand_sample());
        // After a frame sync the pixel count is 2, outside a one-pixel window at 0.
        issue(spa_pkg::FUNC_FRAME, rand_sample());
        issue(spa_pkg::FUNC_PIXEL, rand_sample());

        wait_until_idle();
        if (mismatch_count == 0)
            $display("** sync_driven_pixel_averager: PASSED **");
        else
            $display("** sync_driven_pixel_averager: FAILED **");
        $finish;
    end

endmodule
